[rtl/core/sampled_sparse_dot_product_defines.svh]
// Assertion macros used by the checker file.
`ifndef SAMPLED_SPARSE_DOT_PRODUCT_DEFINES_SVH
`define SAMPLED_SPARSE_DOT_PRODUCT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SSDP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssdp check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SSDP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssdp check failed");

`endif

[rtl/core/ssdp_pkg.sv]
`timescale 1ns / 1ps
package ssdp_pkg;

  localparam int MAX_ROWS   = 1024;
  localparam int MAX_COLS   = 1024;
  localparam int FEAT_DIM   = 4096;
  localparam int U_CAPACITY = 16384;
  localparam int V_CAPACITY = 16384;

  localparam int OP_W   = 3;
  localparam int IDX_W  = 14;
  localparam int PTR_W  = 15;
  localparam int FEAT_W = 12;
  localparam int VAL_W  = 32;
  localparam int MASK_W = 10;
  localparam int ACC_W  = 64;
  localparam int PTR_AW = 11;
  localparam int ENT_AW = 14;

  typedef enum logic [OP_W-1:0] {
    OP_U_PTR = 3'd0,
    OP_U_ENT = 3'd1,
    OP_V_PTR = 3'd2,
    OP_V_ENT = 3'd3,
    OP_QUERY = 3'd4
  } ssdp_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PTR_LO,
    S_PTR_HI,
    S_PTR_END,
    S_FETCH,
    S_EVAL,
    S_DRAIN,
    S_DONE
  } ssdp_state_t;

  // Write request into one matrix store.
  typedef struct packed {
    logic                     ptr_en;
    logic                     ent_en;
    logic [IDX_W-1:0]         addr;
    logic [PTR_W-1:0]         ptr;
    logic [FEAT_W-1:0]        feat;
    logic signed [VAL_W-1:0]  val;
  } ssdp_wr_t;

  // Entry read data.
  typedef struct packed {
    logic [FEAT_W-1:0]        feat;
    logic signed [VAL_W-1:0]  val;
  } ssdp_ent_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
  } ssdp_mac_ctl_t;

endpackage

[rtl/core/ssdp_if.sv]
`timescale 1ns / 1ps
interface ssdp_in_if;
  logic                valid;
  logic                ready;
  logic [2:0]          opcode;
  logic [13:0]         store_index;
  logic [14:0]         pointer_value;
  logic [11:0]         feature_index;
  logic signed [31:0]  entry_value;
  logic [9:0]          mask_row;
  logic [9:0]          mask_col;

  modport source (output valid, opcode, store_index, pointer_value, feature_index,
                  entry_value, mask_row, mask_col, input ready);
  modport sink (input valid, opcode, store_index, pointer_value, feature_index,
                entry_value, mask_row, mask_col, output ready);
endinterface

interface ssdp_out_if;
  logic                valid;
  logic                ready;
  logic signed [63:0]  dot_value;
  logic [9:0]          row_echo;
  logic [9:0]          col_echo;
  logic                saturated;

  modport source (output valid, dot_value, row_echo, col_echo, saturated, input ready);
  modport sink (input valid, dot_value, row_echo, col_echo, saturated, output ready);
endinterface

[rtl/core/ssdp_store.sv]
`timescale 1ns / 1ps
// One matrix: column pointer table and entry table, one read port each.
module ssdp_store (
  input  logic                      clk,
  input  ssdp_pkg::ssdp_wr_t        wr,
  input  logic [ssdp_pkg::PTR_AW-1:0] ptr_addr,
  input  logic [ssdp_pkg::ENT_AW-1:0] ent_addr,
  output logic [ssdp_pkg::PTR_W-1:0]  ptr_data,
  output ssdp_pkg::ssdp_ent_t       ent_data
);
  import ssdp_pkg::*;

  localparam int PTR_DEPTH = MAX_ROWS + 1;
  localparam int ENT_DEPTH = U_CAPACITY;

  logic [PTR_W-1:0] ptr_mem [PTR_DEPTH];
  ssdp_ent_t        ent_mem [ENT_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.ptr_en) begin
      ptr_mem[wr.addr[PTR_AW-1:0]] <= wr.ptr;
    end
    ptr_data <= ptr_mem[ptr_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.ent_en) begin
      ent_mem[wr.addr] <= '{feat: wr.feat, val: wr.val};
    end
    ent_data <= ent_mem[ent_addr];
  end
endmodule

[rtl/core/ssdp_mac.sv]
`timescale 1ns / 1ps
// Registered 32x32 multiply, then saturating 64-bit accumulate.
module ssdp_mac (
  input  logic                          clk,
  input  logic                          rst,
  input  ssdp_pkg::ssdp_mac_ctl_t       ctl,
  input  logic signed [ssdp_pkg::VAL_W-1:0] a,
  input  logic signed [ssdp_pkg::VAL_W-1:0] b,
  output logic signed [ssdp_pkg::ACC_W-1:0] acc,
  output logic                          clamped
);
  import ssdp_pkg::*;

  logic signed [ACC_W-1:0] prod;
  logic                    prod_valid;
  logic signed [ACC_W-1:0] sum;
  logic                    ovf;

  assign sum = acc + prod;
  assign ovf = (acc[ACC_W-1] == prod[ACC_W-1]) && (sum[ACC_W-1] != acc[ACC_W-1]);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= a * b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      prod_valid <= 1'b0;
      acc        <= '0;
      clamped    <= 1'b0;
    end else begin
      prod_valid <= ctl.mul_en;
      if (prod_valid) begin
        if (ovf) begin
          acc     <= acc[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
          clamped <= 1'b1;
        end else begin
          acc <= sum;
        end
      end
    end
  end
endmodule

[rtl/core/sampled_sparse_dot_product.sv]
`timescale 1ns / 1ps
// Load items (pointer or entry writes) are accepted only while no query is in work.
// A query reads the pointers, then runs merge steps (fetch, evaluate), then drains;
//   merge steps are at most nnz(U column) + nnz(V column), set by the single
//   read port of each entry memory. One query is in work at a time.
// Reset clears control and the result valid flag; the memories hold no reset state.
module sampled_sparse_dot_product (
  input logic        clk,
  input logic        rst,
  ssdp_in_if.sink    items,
  ssdp_out_if.source results
);
  import ssdp_pkg::*;

  ssdp_state_t state, state_next;

  // query context
  logic [MASK_W-1:0] row, col;
  logic [PTR_W-1:0]  us, vs, ue, ve;   // clamped column bounds
  logic [PTR_W-1:0]  j, k;             // merge cursors
  logic [PTR_W-1:0]  j_next, k_next;

  // result register
  logic                    out_valid;
  logic signed [ACC_W-1:0] out_dot;
  logic [MASK_W-1:0]       out_row, out_col;
  logic                    out_sat;

  ssdp_wr_t            u_wr, v_wr;
  logic [PTR_AW-1:0]   u_ptr_addr, v_ptr_addr;
  logic [PTR_W-1:0]    u_ptr_data, v_ptr_data;
  ssdp_ent_t           u_ent, v_ent;
  ssdp_mac_ctl_t       mac_ctl;
  logic signed [ACC_W-1:0] acc;
  logic                clamped;

  logic accept;
  logic [PTR_W-1:0] u_ptr_c, v_ptr_c;

  assign items.ready = (state == S_IDLE);
  assign accept      = items.valid && items.ready;

  // ---- store writes: loads land straight in the memories
  always_comb begin
    u_wr.addr   = items.store_index;
    u_wr.ptr    = items.pointer_value;
    u_wr.feat   = items.feature_index;
    u_wr.val    = items.entry_value;
    u_wr.ptr_en = accept && (items.opcode == OP_U_PTR) &&
                  ({1'b0, items.store_index} <= PTR_W'(MAX_ROWS));
    u_wr.ent_en = accept && (items.opcode == OP_U_ENT);
    v_wr        = u_wr;
    v_wr.ptr_en = accept && (items.opcode == OP_V_PTR) &&
                  ({1'b0, items.store_index} <= PTR_W'(MAX_COLS));
    v_wr.ent_en = accept && (items.opcode == OP_V_ENT);
  end

  // pointer reads: column start, then column end
  assign u_ptr_addr = (state == S_PTR_LO) ? {1'b0, row} : {1'b0, row} + PTR_AW'(1);
  assign v_ptr_addr = (state == S_PTR_LO) ? {1'b0, col} : {1'b0, col} + PTR_AW'(1);

  // pointers past the end of the store count as the capacity
  assign u_ptr_c = (u_ptr_data > PTR_W'(U_CAPACITY)) ? PTR_W'(U_CAPACITY) : u_ptr_data;
  assign v_ptr_c = (v_ptr_data > PTR_W'(V_CAPACITY)) ? PTR_W'(V_CAPACITY) : v_ptr_data;

  ssdp_store u_store (
    .clk      (clk),
    .wr       (u_wr),
    .ptr_addr (u_ptr_addr),
    .ent_addr (j[ENT_AW-1:0]),
    .ptr_data (u_ptr_data),
    .ent_data (u_ent)
  );

  ssdp_store v_store (
    .clk      (clk),
    .wr       (v_wr),
    .ptr_addr (v_ptr_addr),
    .ent_addr (k[ENT_AW-1:0]),
    .ptr_data (v_ptr_data),
    .ent_data (v_ent)
  );

  ssdp_mac mac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mac_ctl),
    .a       (u_ent.val),
    .b       (v_ent.val),
    .acc     (acc),
    .clamped (clamped)
  );

  // ---- state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    j_next         = j;
    k_next         = k;
    mac_ctl.clear  = 1'b0;
    mac_ctl.mul_en = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept && (items.opcode == OP_QUERY)) begin
          state_next    = S_PTR_LO;
          mac_ctl.clear = 1'b1;
        end
      end
      S_PTR_LO:  state_next = S_PTR_HI;
      S_PTR_HI:  state_next = S_PTR_END;
      S_PTR_END: begin
        state_next = ((us < u_ptr_c) && (vs < v_ptr_c)) ? S_FETCH : S_DRAIN;
      end
      S_FETCH:   state_next = S_EVAL;
      S_EVAL: begin
        // V cursor skips smaller features; else the U cursor advances, so a match consumes only the U entry
        if (v_ent.feat < u_ent.feat) begin
          k_next = k + PTR_W'(1);
        end else begin
          j_next = j + PTR_W'(1);
          mac_ctl.mul_en = (v_ent.feat == u_ent.feat);
        end
        state_next = ((j_next < ue) && (k_next < ve)) ? S_FETCH : S_DRAIN;
      end
      S_DRAIN:   state_next = S_DONE;   // last product lands in the sum
      S_DONE: begin
        if (!out_valid) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // ---- query context
  always_ff @(posedge clk) begin
    if (accept) begin
      row <= items.mask_row;
      col <= items.mask_col;
    end
    if (state == S_PTR_HI) begin
      us <= u_ptr_c;
      vs <= v_ptr_c;
    end
    if (state == S_PTR_END) begin
      ue <= u_ptr_c;
      ve <= v_ptr_c;
      j  <= us;
      k  <= vs;
    end else if (state == S_EVAL) begin
      j <= j_next;
      k <= k_next;
    end
  end

  // ---- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && !out_valid) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && !out_valid) begin
      out_dot <= acc;
      out_sat <= clamped;
      out_row <= row;
      out_col <= col;
    end
  end

  assign results.valid     = out_valid;
  assign results.dot_value = out_dot;
  assign results.row_echo  = out_row;
  assign results.col_echo  = out_col;
  assign results.saturated = out_sat;
endmodule

[rtl/core/ssdp_checker.sv]
`timescale 1ns / 1ps
`include "sampled_sparse_dot_product_defines.svh"
module ssdp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  in_opcode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_dot,
  input logic [9:0]  out_row,
  input logic [9:0]  out_col
);
  import ssdp_pkg::*;

  `SSDP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `SSDP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
                    $stable(out_dot) && $stable(out_row) && $stable(out_col))
  `SSDP_ASSERT_NOW(a_reset_quiet, $past(rst), !out_valid && in_ready)
  `SSDP_ASSERT_NEXT(a_query_busy, in_valid && in_ready && (in_opcode == OP_QUERY),
                    !in_ready)
endmodule

bind sampled_sparse_dot_product ssdp_checker u_ssdp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (items.valid),
  .in_ready  (items.ready),
  .in_opcode (items.opcode),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_dot   (results.dot_value),
  .out_row   (results.row_echo),
  .out_col   (results.col_echo)
);
